### rtl/fccw_pkg.sv
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types and constants for the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

    localparam int TABLE_BYTES_DEF = 8192;

    // item action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_CONT  = 2'd2;

    // configuration register indexes
    localparam logic CFG_SPC        = 1'b0;
    localparam logic CFG_DATA_START = 1'b1;

    localparam logic [11:0] END_MARK    = 12'hFF8;
    localparam logic [11:0] MIN_CLUSTER = 12'd2;
    localparam logic [6:0]  SPC_MAX     = 7'd64;
    localparam logic [6:0]  SPC_RESET   = 7'd1;
    localparam logic [15:0] DS_RESET    = 16'd33;

    typedef struct packed {
        logic [1:0]  action;
        logic [12:0] table_addr;
        logic [7:0]  table_byte;
        logic [11:0] head_cluster;
    } item_t;

    typedef struct packed {
        logic [19:0] sector_number;
        logic        sector_valid;
        logic        last_of_run;
        logic        chain_done;
        logic        bad_cluster;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic table_wr;
        logic load_first;
        logic rd_hi;
        logic cap_b0;
        logic fin_lookup;
        logic emit_sector;
        logic emit_report;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cl_end;
        logic cl_bad;
        logic last_sector;
    } status_t;

endpackage

### rtl/fat12_cluster_chain_walker_core.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// Walks a FAT12 cluster chain held in an on-chip allocation table.
// ----------------------------------------------------------------------------
// A table write does not make the block busy. A walk step passes the lookup
//   states (address low byte, address high byte with low byte capture, decode)
//   for the two-byte table lookup through the RAM read port, then emits one
//   result per sector; a step at an end marker or bad cluster gives one report.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n, async low): idle, cluster = end marker, spc = 1, data start = 33.
//   Table contents are not cleared.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_core
    import fccw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // command side: transfer when start && !busy
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    // result side: one transfer per strobe cycle
    output result_t     result,
    output logic        result_strobe
);

    cmd_t    cmd;
    status_t sts;

    // Controller: decodes the accepted item and steps through the lookup
    // (address low byte, address high byte + capture low, decode) and then
    // one emission per sector of the cluster, or one report at an end or bad cluster.
    fccw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: the table RAM, the held cluster, the multiply for the
    // cluster base sector and the registered result.  The multiply is
    // registered every cycle and settles during the lookup.
    fccw_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item          (item),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

### rtl/fccw_ram.sv
// ----------------------------------------------------------------------------
// fccw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/fccw_ctrl.sv
// ----------------------------------------------------------------------------
// fccw_ctrl
// Sequencer: table writes, two-byte entry lookup, sector emission.
// ----------------------------------------------------------------------------
module fccw_ctrl
    import fccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] action,
    input  status_t    sts,
    output cmd_t       cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK0,
        ST_LOOK1,
        ST_LOOK2,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_WRITE: cmd.table_wr = 1'b1;
                        ACT_START:
                        begin
                            cmd.load_first = 1'b1;
                            state_next     = ST_LOOK0;
                        end
                        ACT_CONT:  state_next = ST_LOOK0;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOK0:
            begin
                // held cluster is an end marker or bad: one report only
                if (sts.cl_end || sts.cl_bad)
                begin
                    cmd.emit_report = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LOOK1;
                end
            end
            ST_LOOK1:
            begin
                cmd.rd_hi  = 1'b1;
                cmd.cap_b0 = 1'b1;
                state_next = ST_LOOK2;
            end
            ST_LOOK2:
            begin
                cmd.fin_lookup = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_sector = 1'b1;
                if (sts.last_sector)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/fccw_dp.sv
// ----------------------------------------------------------------------------
// fccw_dp
// Datapath: config registers, table RAM, entry decode, sector arithmetic.
// ----------------------------------------------------------------------------
module fccw_dp
    import fccw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  item_t       item,
    input  cmd_t        cmd,
    output status_t     sts,
    output result_t     result,
    output logic        result_strobe
);

    localparam int AW = $clog2(TABLE_BYTES);

    logic [6:0]  spc_reg;
    logic [15:0] ds_reg;
    logic [11:0] cl_reg;
    logic [18:0] prod_reg;
    logic [7:0]  b0_reg;
    logic [11:0] nxt_reg;
    logic        nxt_done_reg;
    logic        nxt_bad_reg;
    logic [19:0] sec_reg;
    logic [5:0]  cnt_reg;
    result_t     result_reg;
    logic        strobe_reg;

    logic [6:0]    spc_eff;
    logic [12:0]   off;
    logic [12:0]   rd_off;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          wr_en;
    logic [7:0]    rdata;
    logic [11:0]   entry;
    logic          entry_bad;
    logic          entry_done;
    logic          last;

    // out-of-range cluster size is clamped to 1..64
    always_comb
    begin
        if (spc_reg == 7'd0)
        begin
            spc_eff = 7'd1;
        end
        else if (spc_reg > SPC_MAX)
        begin
            spc_eff = SPC_MAX;
        end
        else
        begin
            spc_eff = spc_reg;
        end
    end

    // byte offset of entry n is n * 1.5, rounded down
    assign off    = 13'(cl_reg) + 13'(cl_reg[11:1]);
    assign rd_off = cmd.rd_hi ? (off + 13'd1) : off;
    assign raddr  = AW'(rd_off);
    assign waddr  = AW'(item.table_addr);
    assign wr_en  = cmd.table_wr && (32'(item.table_addr) < TABLE_BYTES);

    fccw_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_BYTES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (item.table_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    // even entry: low byte + low nibble; odd entry: high nibble + high byte
    assign entry      = cl_reg[0] ? {rdata, b0_reg[7:4]} : {rdata[3:0], b0_reg};
    assign entry_bad  = (entry < MIN_CLUSTER);
    assign entry_done = (entry >= END_MARK) || entry_bad;

    assign last = (cnt_reg == 6'(spc_eff - 7'd1));

    assign sts.cl_end      = (cl_reg >= END_MARK);
    assign sts.cl_bad      = (cl_reg < MIN_CLUSTER);
    assign sts.last_sector = last;

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg    <= SPC_RESET;
            ds_reg     <= DS_RESET;
            cl_reg     <= END_MARK;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPC:        spc_reg <= cfg_data[6:0];
                    CFG_DATA_START: ds_reg  <= cfg_data;
                    default:        spc_reg <= spc_reg;
                endcase
            end
            if (cmd.load_first)
            begin
                cl_reg <= item.head_cluster;
            end
            else if (cmd.emit_sector && last)
            begin
                cl_reg <= nxt_reg;
            end
            strobe_reg <= cmd.emit_sector || cmd.emit_report;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 19'(cl_reg - MIN_CLUSTER) * 19'(spc_eff);
        if (cmd.cap_b0)
        begin
            b0_reg <= rdata;
        end
        if (cmd.fin_lookup)
        begin
            nxt_reg      <= entry;
            nxt_bad_reg  <= entry_bad;
            nxt_done_reg <= entry_done;
            sec_reg      <= 20'(prod_reg) + 20'(ds_reg);
            cnt_reg      <= 6'd0;
        end
        else if (cmd.emit_sector)
        begin
            sec_reg <= sec_reg + 20'd1;
            cnt_reg <= cnt_reg + 6'd1;
        end
        if (cmd.emit_sector)
        begin
            result_reg.sector_number <= sec_reg;
            result_reg.sector_valid  <= 1'b1;
            result_reg.last_of_run   <= last;
            result_reg.chain_done    <= last && nxt_done_reg;
            result_reg.bad_cluster   <= last && nxt_bad_reg;
        end
        else if (cmd.emit_report)
        begin
            result_reg.sector_number <= 20'd0;
            result_reg.sector_valid  <= 1'b0;
            result_reg.last_of_run   <= 1'b1;
            result_reg.chain_done    <= 1'b1;
            result_reg.bad_cluster   <= sts.cl_bad;
        end
    end

endmodule

### rtl/fccw_checker.sv
// ----------------------------------------------------------------------------
// fccw_checker
// Port-level checks on result flags and busy behavior of the walker.
// ----------------------------------------------------------------------------
module fccw_checker
    import fccw_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input result_t result,
    input logic    result_strobe
);

    // a report result always closes the step and the chain
    a_report_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.sector_valid) |->
            (result.last_of_run && result.chain_done))
        else $error("report result without last/done");

    // chain flags only on the final result of a step
    a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (result.chain_done || result.bad_cluster)) |->
            result.last_of_run)
        else $error("chain flag on a non-final result");

    a_bad_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.bad_cluster) |-> result.chain_done)
        else $error("bad cluster without chain done");

    // a table write never occupies the block
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action == ACT_WRITE)) |=> !busy)
        else $error("busy after table write");

    // a walk item occupies the block and yields no result in the next cycle
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.action == ACT_START || item.action == ACT_CONT))
            |=> (busy && !result_strobe))
        else $error("walk item did not start a step");

endmodule

bind fat12_cluster_chain_walker_core fccw_checker u_fccw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result        (result),
    .result_strobe (result_strobe)
);

### tb/fat12_cluster_chain_walker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core_test
// Self-checking bench for the FAT12 chain walker. Builds cluster chains in
// the allocation table through byte-write transfers, walks them with start
// and continue transfers, and checks every sector strobe against a local
// model of the table, the held cluster and the two registers.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_core_test;

    import fccw_pkg::*;

    // action code the block must ignore
    localparam logic [1:0] ACT_NONE = 2'd3;

    // highest cluster that still addresses a data cluster
    localparam logic [11:0] LAST_DATA_CLUSTER = 12'hFF7;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        start;
    item_t       item_in;
    logic        busy;
    result_t     result_out;
    logic        result_strobe;

    fat12_cluster_chain_walker_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .item          (item_in),
        .busy          (busy),
        .result        (result_out),
        .result_strobe (result_strobe)
    );

    // ------------------------------------------------------------------
    // Local copy of the block state, advanced at every accepted transfer.
    // tbl_written marks bytes loaded so far; a walk is never sent that
    // would look up an entry whose bytes were not loaded.
    // ------------------------------------------------------------------
    logic [7:0]  tbl_mirror  [TABLE_BYTES_DEF];
    bit          tbl_written [TABLE_BYTES_DEF];
    logic [11:0] cur_cluster;
    logic [6:0]  spc_reg;
    logic [15:0] ds_reg;

    // sector results still owed by the block, oldest first
    result_t     sector_q[$];

    bit          allow_gaps;
    int unsigned n_items;
    int unsigned n_ignored;
    int unsigned n_walks;
    int unsigned n_writes;
    int unsigned n_end_reports;
    int unsigned n_bad_reports;
    int unsigned n_checked;
    int unsigned n_errors;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops results.
    initial
    begin
        #3_000_000;
        $display("tb: run did not complete in the allotted time");
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic result_t sector_rec(input logic [19:0] num, input logic valid,
                                           input logic last, input logic done,
                                           input logic bad);
        result_t r;
        r.sector_number = num;
        r.sector_valid  = valid;
        r.last_of_run   = last;
        r.chain_done    = done;
        r.bad_cluster   = bad;
        return r;
    endfunction

    // 12-bit table entry of a cluster: even entries take the whole low byte
    // plus the low nibble of the next, odd ones the high nibble plus the
    // whole next byte.
    function automatic logic [11:0] entry_of(input logic [11:0] cl);
        int         off;
        logic [7:0] lo;
        logic [7:0] hi;
        off = int'(cl) * 3 / 2;
        lo  = tbl_mirror[off];
        hi  = tbl_mirror[off + 1];
        if (!cl[0])
            return {hi[3:0], lo};
        return {hi, lo[7:4]};
    endfunction

    // One walk step at the held cluster.
    task automatic predict_walk();
        logic [11:0] nxt;
        logic        done;
        logic        bad;
        int          n_sec;
        int          base;
        n_walks++;
        if (cur_cluster >= END_MARK)
        begin
            sector_q.push_back(sector_rec(20'd0, 1'b0, 1'b1, 1'b1, 1'b0));
            n_end_reports++;
        end
        else if (cur_cluster < MIN_CLUSTER)
        begin
            // held cluster stays as it is
            sector_q.push_back(sector_rec(20'd0, 1'b0, 1'b1, 1'b1, 1'b1));
            n_bad_reports++;
        end
        else
        begin
            // register value 0 behaves as 1, anything above 64 as 64
            n_sec = (spc_reg == 7'd0) ? 1 : (spc_reg > SPC_MAX) ? int'(SPC_MAX) : int'(spc_reg);
            nxt   = entry_of(cur_cluster);
            bad   = (nxt < MIN_CLUSTER);
            done  = bad || (nxt >= END_MARK);
            base  = (int'(cur_cluster) - 2) * n_sec + int'(ds_reg);
            for (int i = 0; i < n_sec; i++)
            begin
                if (i == n_sec - 1)
                    sector_q.push_back(sector_rec(20'(base + i), 1'b1, 1'b1, done, bad));
                else
                    sector_q.push_back(sector_rec(20'(base + i), 1'b1, 1'b0, 1'b0, 1'b0));
            end
            cur_cluster = nxt;
        end
    endtask

    task automatic predict_transfer(input item_t it);
        case (it.action)
            ACT_WRITE:
            begin
                tbl_mirror[it.table_addr]  = it.table_byte;
                tbl_written[it.table_addr] = 1'b1;
                n_writes++;
            end
            ACT_START:
            begin
                cur_cluster = it.head_cluster;
                predict_walk();
            end
            ACT_CONT:
                predict_walk();
            default:
                n_ignored++;
        endcase
        if (it.action != ACT_NONE)
            n_items++;
    endtask

    // ------------------------------------------------------------------
    // Result checking: every strobe pops the oldest expected sector.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [19:0] want,
                                   input logic [19:0] got);
        n_errors++;
        if (n_errors <= 30)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_strobe)
        begin
            if (sector_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 30)
                    $display("%0t: unexpected result, expected none, got sector %0d",
                             $time, result_out.sector_number);
            end
            else
            begin
                want = sector_q.pop_front();
                n_checked++;
                if (result_out.sector_number !== want.sector_number)
                    report_mismatch("sector_number", want.sector_number,
                                    result_out.sector_number);
                if (result_out.sector_valid !== want.sector_valid)
                    report_mismatch("sector_valid", 20'(want.sector_valid),
                                    20'(result_out.sector_valid));
                if (result_out.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 20'(want.last_of_run),
                                    20'(result_out.last_of_run));
                if (result_out.chain_done !== want.chain_done)
                    report_mismatch("chain_done", 20'(want.chain_done),
                                    20'(result_out.chain_done));
                if (result_out.bad_cluster !== want.bad_cluster)
                    report_mismatch("bad_cluster", 20'(want.bad_cluster),
                                    20'(result_out.bad_cluster));
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side. Every task starts and ends on a rising edge, so start
    // never gets two assignments in one step: it is only lowered by a gap
    // or a drain, after time has moved on.
    // ------------------------------------------------------------------
    task automatic idle_for(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Transfer happens at the first edge with start high and busy low.
    task automatic send_item(input item_t it);
        start   <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_transfer(it);
        if (allow_gaps && $urandom_range(0, 2) == 0)
            idle_for($urandom_range(1, 19));
    endtask

    // unused fields carry random values so every bit gets toggled
    function automatic item_t rand_fields(input logic [1:0] act);
        item_t it;
        it.action       = act;
        it.table_addr   = 13'($urandom_range(0, TABLE_BYTES_DEF - 1));
        it.table_byte   = 8'($urandom_range(0, 255));
        it.head_cluster = 12'($urandom_range(0, 4095));
        return it;
    endfunction

    task automatic do_write(input logic [12:0] addr, input logic [7:0] data);
        item_t it;
        it            = rand_fields(ACT_WRITE);
        it.table_addr = addr;
        it.table_byte = data;
        send_item(it);
    endtask

    task automatic do_nop();
        send_item(rand_fields(ACT_NONE));
    endtask

    // Store a 12-bit entry, keeping the nibble that belongs to the neighbor.
    task automatic write_entry(input logic [11:0] cl, input logic [11:0] val);
        int         off;
        logic [7:0] lo;
        logic [7:0] hi;
        off = int'(cl) * 3 / 2;
        lo  = tbl_mirror[off];
        hi  = tbl_mirror[off + 1];
        if (!cl[0])
        begin
            lo = val[7:0];
            hi = {hi[7:4], val[11:8]};
        end
        else
        begin
            lo = {val[3:0], lo[3:0]};
            hi = val[11:4];
        end
        do_write(13'(off), lo);
        do_write(13'(off + 1), hi);
    endtask

    // Before a walk at cl, load its entry if either byte was never written.
    task automatic ensure_entry(input logic [11:0] cl);
        int off;
        off = int'(cl) * 3 / 2;
        if (cl >= MIN_CLUSTER && cl < END_MARK && !(tbl_written[off] && tbl_written[off + 1]))
        begin
            case ($urandom_range(0, 3))
                0:       write_entry(cl, 12'(END_MARK + $urandom_range(0, 7)));
                1:       write_entry(cl, 12'($urandom_range(0, 4095)));
                default: write_entry(cl, 12'($urandom_range(2, 200)));
            endcase
        end
    endtask

    task automatic do_start(input logic [11:0] cl);
        item_t it;
        ensure_entry(cl);
        it              = rand_fields(ACT_START);
        it.head_cluster = cl;
        send_item(it);
    endtask

    task automatic do_cont();
        ensure_entry(cur_cluster);
        send_item(rand_fields(ACT_CONT));
    endtask

    // Hold off until every owed result has arrived, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (sector_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Register write: one cycle of enable, then enable is lowered again.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SPC)
            spc_reg = val[6:0];
        else
            ds_reg = val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] spc, input logic [15:0] ds);
        drain();
        write_reg(CFG_SPC, spc);
        write_reg(CFG_DATA_START, ds);
    endtask

    function automatic logic [11:0] pick_cluster();
        if ($urandom_range(0, 3) == 0)
            return 12'($urandom_range(2, LAST_DATA_CLUSTER));
        return 12'($urandom_range(2, 200));
    endfunction

    // File of one to five linked clusters and a tail (mostly an end marker,
    // else bad or another cluster), then a start and continues onto the tail.
    task automatic run_chain();
        logic [11:0] hops[$];
        logic [11:0] tail;
        int unsigned len;
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
            hops.push_back(pick_cluster());
        case ($urandom_range(0, 9))
            0, 1:    tail = 12'($urandom_range(0, 1));
            2:       tail = pick_cluster();
            default: tail = 12'(END_MARK + $urandom_range(0, 7));
        endcase
        for (int k = 0; k < len; k++)
            write_entry(hops[k], (k + 1 < len) ? hops[k + 1] : tail);
        do_start(hops[0]);
        repeat (len + $urandom_range(0, 1))
            do_cont();
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // After reset the held cluster is the end marker; action 3 is dropped.
    task automatic test_reset_state();
        do_cont();
        do_nop();
    endtask

    // Two-cluster file at reset registers: entry 2 (even) and 3 (odd) share
    // a byte, so both nibble rules are used.
    task automatic test_short_chain();
        write_entry(12'd2, 12'd3);
        write_entry(12'd3, 12'hFFF);
        do_start(12'd2);
        do_cont();
        do_cont();
    endtask

    // Bad clusters, end markers and the last data cluster of the table.
    task automatic test_edge_clusters();
        do_start(12'd0);
        do_cont();
        do_start(12'd1);
        do_start(12'hFFF);
        do_start(END_MARK);
        write_entry(LAST_DATA_CLUSTER, 12'd0);
        do_start(LAST_DATA_CLUSTER);
        do_cont();
    endtask

    // Register extremes, including sector counts outside 1..64.
    task automatic test_config_extremes();
        set_config(16'd64, 16'hFFFF);
        do_start(LAST_DATA_CLUSTER);
        do_cont();
        set_config(16'd0, 16'd0);
        do_start(12'd2);
        do_cont();
        set_config(16'd100, 16'd4000);
        do_start(12'd3);
    endtask

    // ------------------------------------------------------------------
    // Random walks over several register settings; mostly chains, some
    // stray writes, ignored actions, random starts and lone continues.
    // The last phase runs without gaps.
    // ------------------------------------------------------------------
    task automatic test_random_walks();
        int unsigned mark;
        int unsigned pick;
        int unsigned spc_pick;
        int unsigned ds_pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                spc_pick = 1;
            else if (phase == 1)
                spc_pick = 64;
            else if ($urandom_range(0, 4) == 0)
                spc_pick = $urandom_range(1, 64);
            else
                spc_pick = $urandom_range(1, 8);
            if (phase == 2)
                ds_pick = 0;
            else if (phase == 3)
                ds_pick = 16'hFFFF;
            else
                ds_pick = $urandom_range(0, 16'hFFFF);
            set_config(16'(spc_pick), 16'(ds_pick));
            mark = n_items;
            while (n_items - mark < 60)
            begin
                allow_gaps = (phase != 7) && ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    run_chain();
                else if (pick < 78)
                    do_write(13'($urandom_range(0, TABLE_BYTES_DEF - 1)),
                             8'($urandom_range(0, 255)));
                else if (pick < 84)
                    do_nop();
                else if (pick < 92)
                    do_start(12'($urandom_range(0, 4095)));
                else if (pick < 97 || phase == 7)
                    do_cont();
                else
                    drain();
            end
        end
        allow_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item_in   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SPC;
        cfg_data  = '0;
        for (int a = 0; a < TABLE_BYTES_DEF; a++)
        begin
            tbl_mirror[a]  = 8'd0;
            tbl_written[a] = 1'b0;
        end
        cur_cluster   = END_MARK;
        spc_reg       = SPC_RESET;
        ds_reg        = DS_RESET;
        allow_gaps    = 1'b1;
        n_items       = 0;
        n_ignored     = 0;
        n_walks       = 0;
        n_writes      = 0;
        n_end_reports = 0;
        n_bad_reports = 0;
        n_checked     = 0;
        n_errors      = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_short_chain();
        test_edge_clusters();
        test_config_extremes();
        test_random_walks();
        drain();

        $display("tb: %0d transfers in: %0d walk steps, %0d table writes, %0d ignored",
                 n_items + n_ignored, n_walks, n_writes, n_ignored);
        $display("tb: %0d results checked (%0d end-of-chain, %0d bad-cluster reports)",
                 n_checked, n_end_reports, n_bad_reports);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
